FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/rggc_pkg.sv
// Types, constants and fixed-point helpers for the gray gamma correction unit.
package rggc_pkg;

    localparam int QBITS      = 24;
    localparam int SER_TERMS  = 6;
    localparam int SUM_W      = 26;
    localparam int WSUM_W     = 18;
    localparam int DEN_W      = 26;
    localparam int DIV_QBITS  = 26;
    localparam int DIV_STEP   = 2;
    localparam int DIV_ST     = DIV_QBITS / DIV_STEP;

    localparam logic [15:0] RST_WEIGHT_RED   = 16'd1225;
    localparam logic [15:0] RST_WEIGHT_GREEN = 16'd2404;
    localparam logic [15:0] RST_WEIGHT_BLUE  = 16'd467;
    localparam logic [15:0] RST_GAMMA        = 16'd4096;

    typedef enum logic [1:0] {
        CFG_WEIGHT_RED   = 2'd0,
        CFG_WEIGHT_GREEN = 2'd1,
        CFG_WEIGHT_BLUE  = 2'd2,
        CFG_GAMMA        = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] gray_out;
        logic       weight_error;
    } t_pix_out;

    // Sign a rounded magnitude and saturate to Q8.24.
    function automatic logic [31:0] signed_sat(input logic [63:0] r, input logic neg);
        logic [63:0] nr;
        nr = -r;
        if (neg) begin
            return (r > 64'h8000_0000) ? 32'h8000_0000 : nr[31:0];
        end
        return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
    endfunction

    // Rounded, saturated product shifted right by sh.
    function automatic logic [31:0] mul_sh(input logic signed [32:0] a,
                                           input logic signed [32:0] b,
                                           input int unsigned sh);
        logic        neg;
        logic [32:0] na;
        logic [32:0] nb;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] p;
        logic [63:0] r;
        neg = a[32] ^ b[32];
        na  = -a;
        nb  = -b;
        ma  = a[32] ? na[31:0] : a[31:0];
        mb  = b[32] ? nb[31:0] : b[31:0];
        p   = 64'(ma) * 64'(mb);
        r   = (p + (64'd1 << (sh - 1))) >> sh;
        return signed_sat(r, neg);
    endfunction

    // Series divisor of power p.
    function automatic int unsigned ser_div(input bit is_exp, input int p);
        int unsigned k;
        k = 1;
        if (is_exp) begin
            for (int i = 2; i <= p; i++) begin
                k = k * i;
            end
        end else begin
            k = p;
        end
        return k;
    endfunction

endpackage

FILE: rtl/rggc_series.sv
// Pipelined six-term power series for ln(1+d) or exp(y) in Q8.24.
module rggc_series #(
    parameter bit IS_EXP = 1'b0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic        i_flag,
    input  logic [31:0] i_x,
    output logic        o_vld,
    output logic        o_flag,
    output logic [31:0] o_y
);
    import rggc_pkg::*;

    localparam int LAT = SER_TERMS + 2;
    localparam int PST = SER_TERMS - 1;

    typedef logic [SER_TERMS:1][31:0] t_pw;

    t_pw          r_pw [1:PST];
    t_pw          n_pw [1:PST];
    logic [LAT:1] r_vld;
    logic [LAT:1] r_flg;

    logic [31:0] r_ax [2:SER_TERMS];
    logic [31:0] r_aq [2:SER_TERMS];
    logic        r_an [2:SER_TERMS];
    logic [31:0] r_bt [2:SER_TERMS];
    logic [31:0] r_a1;
    logic [31:0] r_b1;
    logic [31:0] r_y;
    logic [31:0] n_y;

    always_comb begin
        n_pw[1]    = '0;
        n_pw[1][1] = i_x;
        n_pw[1][2] = mul_sh({i_x[31], i_x}, {i_x[31], i_x}, QBITS);
        for (int j = 2; j <= PST; j++) begin
            n_pw[j]      = r_pw[j-1];
            n_pw[j][j+1] = mul_sh({r_pw[j-1][j][31], r_pw[j-1][j]},
                                  {r_pw[j-1][1][31], r_pw[j-1][1]}, QBITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-1:1], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flg <= {r_flg[LAT-1:1], i_flag};
            for (int j = 1; j <= PST; j++) begin
                r_pw[j] <= n_pw[j];
            end
            r_a1 <= r_pw[PST][1];
            r_b1 <= r_a1;
            r_y  <= n_y;
        end
    end

    for (genvar p = 2; p <= SER_TERMS; p++) begin : g_term
        localparam int unsigned K = ser_div(IS_EXP, p);
        localparam logic [31:0] M = 32'((64'd1 << 32) / K);

        logic [31:0] w_v;
        logic [31:0] w_mag;
        logic [31:0] w_x;
        logic [63:0] w_prd;
        logic [31:0] w_rem;
        logic [31:0] w_q;

        assign w_v   = r_pw[PST][p];
        assign w_mag = w_v[31] ? (32'd0 - w_v) : w_v;
        assign w_x   = w_mag + 32'(K / 2);
        assign w_prd = 64'(w_x) * 64'(M);
        assign w_rem = r_ax[p] - r_aq[p] * 32'(K);
        assign w_q   = (w_rem >= 32'(K)) ? r_aq[p] + 32'd1 : r_aq[p];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ax[p] <= w_x;
                r_aq[p] <= w_prd[63:32];
                r_an[p] <= w_v[31];
                r_bt[p] <= signed_sat(64'(w_q), r_an[p]);
            end
        end
    end

    always_comb begin
        logic signed [35:0] acc;
        acc = IS_EXP ? 36'sd16777216 : 36'sd0;
        acc = acc + 36'($signed(r_b1));
        for (int p = 2; p <= SER_TERMS; p++) begin
            if (!IS_EXP && (p % 2 == 0)) begin
                acc = acc - 36'($signed(r_bt[p]));
            end else begin
                acc = acc + 36'($signed(r_bt[p]));
            end
        end
        if (acc > 36'sh0_7FFF_FFFF) begin
            n_y = 32'h7FFF_FFFF;
        end else if (acc < -36'sh0_8000_0000) begin
            n_y = 32'h8000_0000;
        end else begin
            n_y = acc[31:0];
        end
    end

    assign o_vld  = r_vld[LAT];
    assign o_flag = r_flg[LAT];
    assign o_y    = r_y;

endmodule

FILE: rtl/rgb_gray_gamma_correct_unit.sv
// Top level: RGB to gray conversion with gamma correction, fully pipelined.
// Throughput: one pixel per cycle while the output is not stalled.
// The 13-stage divider and the two 8-stage series set the depth.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Reset (sync, active low) clears valids and loads default weights and gamma.
`include "assert_macros.svh"
module rgb_gray_gamma_correct_unit #(
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rggc_pkg::t_pix_in  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rggc_pkg::t_pix_out o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import rggc_pkg::*;

    logic [15:0] r_wr, r_wg, r_wb, r_gamma;
    logic [DEN_W-1:0]  r_den;
    logic [WSUM_W-1:0] w_wsum;
    logic [DEN_W-1:0]  w_den;
    logic              w_wsum_zero;
    logic              w_en;

    logic              r_s1_vld, r_s1_err;
    logic [SUM_W-1:0]  r_s1_s;
    logic [SUM_W-1:0]  w_s;
    logic [51:0]       w_num;

    logic                 r_dv [0:DIV_ST];
    logic                 r_de [0:DIV_ST];
    logic [DEN_W-1:0]     r_dr [0:DIV_ST];
    logic [DIV_QBITS-1:0] r_dn [0:DIV_ST];
    logic [DIV_QBITS-1:0] r_dq [0:DIV_ST];
    logic [DEN_W-1:0]     n_dr [1:DIV_ST];
    logic [DIV_QBITS-1:0] n_dn [1:DIV_ST];
    logic [DIV_QBITS-1:0] n_dq [1:DIV_ST];

    logic [31:0] w_d;
    logic        w_lg_vld, w_lg_err;
    logic [31:0] w_lg;
    logic        r_g_vld, r_g_err;
    logic [31:0] r_g_y;
    logic        w_ex_vld, w_ex_err;
    logic [31:0] w_ex;

    logic        r_out_vld;
    t_pix_out    r_out;
    t_pix_out    n_out;
    logic [39:0] w_e255;
    logic [15:0] w_e8;

    assign w_en        = !r_out_vld || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= RST_WEIGHT_RED;
            r_wg    <= RST_WEIGHT_GREEN;
            r_wb    <= RST_WEIGHT_BLUE;
            r_gamma <= RST_GAMMA;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WEIGHT_RED:   r_wr    <= i_cfg_data;
                CFG_WEIGHT_GREEN: r_wg    <= i_cfg_data;
                CFG_WEIGHT_BLUE:  r_wb    <= i_cfg_data;
                CFG_GAMMA:        r_gamma <= i_cfg_data;
                default:          r_gamma <= r_gamma;
            endcase
        end
    end

    assign w_wsum      = {2'b0, r_wr} + {2'b0, r_wg} + {2'b0, r_wb};
    assign w_den       = {w_wsum, 8'b0} - {8'b0, w_wsum};
    assign w_wsum_zero = (w_wsum == '0);

    always_ff @(posedge i_clk) begin
        r_den <= w_den;
    end

    // weighted channel sum
    assign w_s = {10'b0, r_wr} * {18'b0, i_in_data.red}
               + {10'b0, r_wg} * {18'b0, i_in_data.green}
               + {10'b0, r_wb} * {18'b0, i_in_data.blue};

    assign w_num = {2'b0, r_s1_s, 24'b0} + {27'b0, r_den[DEN_W-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_dv[0]  <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_in_valid;
            r_dv[0]  <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_s   <= w_s;
            r_s1_err <= w_wsum_zero;
            r_de[0]  <= r_s1_err;
            r_dr[0]  <= w_num[51:26];
            r_dn[0]  <= w_num[25:0];
            r_dq[0]  <= '0;
        end
    end

    // restoring divider, two quotient bits per stage
    for (genvar j = 1; j <= DIV_ST; j++) begin : g_div
        always_comb begin
            logic [DEN_W-1:0]     t_rem;
            logic [DIV_QBITS-1:0] t_lo;
            logic [DIV_QBITS-1:0] t_q;
            logic [DEN_W:0]       t_sh;
            t_rem = r_dr[j-1];
            t_lo  = r_dn[j-1];
            t_q   = r_dq[j-1];
            for (int b = 0; b < DIV_STEP; b++) begin
                t_sh = {t_rem, t_lo[DIV_QBITS-1]};
                t_lo = {t_lo[DIV_QBITS-2:0], 1'b0};
                if (t_sh >= {1'b0, r_den}) begin
                    t_sh  = t_sh - {1'b0, r_den};
                    t_rem = t_sh[DEN_W-1:0];
                    t_q   = {t_q[DIV_QBITS-2:0], 1'b1};
                end else begin
                    t_rem = t_sh[DEN_W-1:0];
                    t_q   = {t_q[DIV_QBITS-2:0], 1'b0};
                end
            end
            n_dr[j] = t_rem;
            n_dn[j] = t_lo;
            n_dq[j] = t_q;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j] <= 1'b0;
            end else if (w_en) begin
                r_dv[j] <= r_dv[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_de[j] <= r_de[j-1];
                r_dr[j] <= n_dr[j];
                r_dn[j] <= n_dn[j];
                r_dq[j] <= n_dq[j];
            end
        end
    end

    assign w_d = {6'b0, r_dq[DIV_ST]} - 32'h0100_0000;

    rggc_series #(.IS_EXP(1'b0)) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_dv[DIV_ST]),
        .i_flag  (r_de[DIV_ST]),
        .i_x     (w_d),
        .o_vld   (w_lg_vld),
        .o_flag  (w_lg_err),
        .o_y     (w_lg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else if (w_en) begin
            r_g_vld <= w_lg_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_err <= w_lg_err;
            r_g_y   <= mul_sh({17'b0, r_gamma}, {w_lg[31], w_lg}, COEF_FRAC_BITS);
        end
    end

    rggc_series #(.IS_EXP(1'b1)) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_g_vld),
        .i_flag  (r_g_err),
        .i_x     (r_g_y),
        .o_vld   (w_ex_vld),
        .o_flag  (w_ex_err),
        .o_y     (w_ex)
    );

    assign w_e255 = {w_ex, 8'b0} - {8'b0, w_ex} + (40'd1 << 23);
    assign w_e8   = w_e255[39:24];

    always_comb begin
        n_out.weight_error = w_ex_err;
        if (w_ex_err || w_ex[31] || (w_ex == '0)) begin
            n_out.gray_out = '0;
        end else if (w_e8 > 16'd255) begin
            n_out.gray_out = 8'd255;
        end else begin
            n_out.gray_out = w_e8[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_ex_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_out_valid && o_out_data.weight_error, o_out_data.gray_out == 8'd0)
    `ASSERT_IMPL(a_err_cfg, i_clk, i_rst_n, o_out_valid, o_out_data.weight_error == w_wsum_zero)
    `ASSERT_IMPL(a_stall_in, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready)
    `ASSERT_NEXT(a_div_hold, i_clk, i_rst_n, r_dv[DIV_ST] && !o_in_ready, r_dv[DIV_ST])

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the RGB to gray gamma correction unit.
`timescale 1ns / 1ps
module testbench;
    import rggc_pkg::*;

    localparam longint QONE = 64'sd1 << 24;
    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;
    localparam int CYCLE_LIMIT = 2000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_pix_in    i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_pix_out   o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    rgb_gray_gamma_correct_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    logic [15:0] wt_red, wt_green, wt_blue, gamma_q;
    t_pix_out    gray_expected[$];
    int          errors = 0;
    int          pixels_sent = 0;
    int          grays_checked = 0;
    int          flags_seen = 0;
    int          cfg_writes = 0;
    int          burst_left = 0;
    int          cycles = 0;
    int          stall_mode = 0;

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // fixed-point helpers at Q8.24
    function automatic longint unsigned q_mag(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint q_sign_sat(input longint unsigned r, input bit neg);
        if (neg) return (r > 64'h8000_0000) ? QMIN : -longint'(r);
        return (r > 64'h7FFF_FFFF) ? QMAX : longint'(r);
    endfunction

    function automatic longint q_sat(input longint v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    function automatic longint q_mul(input longint a, input longint b, input int sh);
        longint unsigned p;
        p = q_mag(a) * q_mag(b);
        p = (p + (64'd1 << (sh - 1))) >> sh;
        return q_sign_sat(p, (a < 0) != (b < 0));
    endfunction

    function automatic longint q_div(input longint v, input longint unsigned k);
        return q_sign_sat((q_mag(v) + k / 2) / k, v < 0);
    endfunction

    function automatic t_pix_out gray_gamma_predict(input t_pix_in p);
        t_pix_out o;
        longint unsigned wsum, s, den, e255;
        longint g, d, p2, p3, p4, p5, p6, lg, y, e;
        o = '0;
        wsum = longint'(wt_red) + wt_green + wt_blue;
        if (wsum == 0) begin
            o.weight_error = 1'b1;
            return o;
        end
        s = longint'(wt_red) * p.red + longint'(wt_green) * p.green
          + longint'(wt_blue) * p.blue;
        den = wsum * 255;
        g = ((s << 24) + den / 2) / den;
        d = g - QONE;
        p2 = q_mul(d, d, 24);
        p3 = q_mul(p2, d, 24);
        p4 = q_mul(p3, d, 24);
        p5 = q_mul(p4, d, 24);
        p6 = q_mul(p5, d, 24);
        lg = q_sat(d + q_div(p3, 3) + q_div(p5, 5)
                   - q_div(p2, 2) - q_div(p4, 4) - q_div(p6, 6));
        y = q_mul(longint'(gamma_q), lg, 12);
        p2 = q_mul(y, y, 24);
        p3 = q_mul(p2, y, 24);
        p4 = q_mul(p3, y, 24);
        p5 = q_mul(p4, y, 24);
        p6 = q_mul(p5, y, 24);
        e = q_sat(QONE + y + q_div(p2, 2) + q_div(p3, 6) + q_div(p4, 24)
                  + q_div(p5, 120) + q_div(p6, 720));
        if (e > 0) begin
            e255 = (longint'(e) * 255 + (64'd1 << 23)) >> 24;
            o.gray_out = (e255 > 255) ? 8'd255 : e255[7:0];
        end
        return o;
    endfunction

    // receiver stall pattern: free-running, random, or mostly stalled
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_pix_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (gray_expected.size() == 0) begin
                $display("%0t unexpected transfer: actual %p", $time, o_out_data);
                errors++;
            end else begin
                want = gray_expected.pop_front();
                grays_checked++;
                if (want.weight_error) flags_seen++;
                if (o_out_data.gray_out !== want.gray_out) begin
                    $display("%0t gray_out expected %0d actual %0d", $time,
                             want.gray_out, o_out_data.gray_out);
                    errors++;
                end
                if (o_out_data.weight_error !== want.weight_error) begin
                    $display("%0t weight_error expected %0b actual %0b", $time,
                             want.weight_error, o_out_data.weight_error);
                    errors++;
                end
            end
        end
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_pix_in p;
        int gap;
        p = '{red: r, green: g, blue: b};
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        do @(posedge i_clk); while (!o_in_ready);
        gray_expected.push_back(gray_gamma_predict(p));
        pixels_sent++;
        burst_left--;
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (gray_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_WEIGHT_RED:   wt_red = val;
            CFG_WEIGHT_GREEN: wt_green = val;
            CFG_WEIGHT_BLUE:  wt_blue = val;
            CFG_GAMMA:        gamma_q = val;
        endcase
        cfg_writes++;
    endtask

    task automatic set_config(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b, input logic [15:0] gm);
        drain();
        write_reg(CFG_WEIGHT_RED, r);
        write_reg(CFG_WEIGHT_GREEN, g);
        write_reg(CFG_WEIGHT_BLUE, b);
        write_reg(CFG_GAMMA, gm);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_defaults;
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd128, 8'd64, 8'd32);
        send_pixel(8'd1, 8'd1, 8'd1);
    endtask

    task automatic test_zero_weight_sum;
        set_config(16'd0, 16'd0, 16'd0, 16'd4096);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd170, 8'd85, 8'd15);
    endtask

    task automatic test_gamma_extremes;
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd100, 8'd100, 8'd100);
        set_config(16'd4096, 16'd0, 16'd0, 16'hFFFF);
        send_pixel(8'd0, 8'd9, 8'd9);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd200, 8'd0, 8'd0);
        send_pixel(8'd20, 8'd0, 8'd0);
        set_config(16'd1, 16'd0, 16'd65535, 16'd1);
        send_pixel(8'd255, 8'd7, 8'd0);
        send_pixel(8'd3, 8'd7, 8'd250);
        set_config(16'd0, 16'd0, 16'd1, 16'd9000);
        send_pixel(8'd0, 8'd0, 8'd1);
    endtask

    task automatic test_random_phases;
        logic [15:0] cv[4];
        for (int ph = 0; ph < 9; ph++) begin
            for (int k = 0; k < 4; k++) begin
                case ($urandom_range(0, 4))
                    0: cv[k] = 16'd0;
                    1: cv[k] = 16'hFFFF;
                    2: cv[k] = 16'($urandom_range(0, 8192));
                    default: cv[k] = 16'($urandom_range(0, 65535));
                endcase
            end
            if (ph == 0) cv = '{16'd1225, 16'd2404, 16'd467, 16'd4096};
            set_config(cv[0], cv[1], cv[2], cv[3]);
            repeat (140) send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_WEIGHT_RED;
        i_cfg_data = '0;
        wt_red = RST_WEIGHT_RED;
        wt_green = RST_WEIGHT_GREEN;
        wt_blue = RST_WEIGHT_BLUE;
        gamma_q = RST_GAMMA;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_zero_weight_sum();
        test_gamma_extremes();
        test_random_phases();
        drain();
        repeat (60) @(posedge i_clk);
        $display("pixels %0d, grays checked %0d, zero-weight flags %0d, register writes %0d",
                 pixels_sent, grays_checked, flags_seen, cfg_writes);
        $display("covered default, zero, extreme and random weight/gamma settings");
        if (errors == 0 && gray_expected.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl
rtl/rggc_pkg.sv
rtl/rggc_series.sv
rtl/rgb_gray_gamma_correct_unit.sv
bench/testbench.sv
